FILE: hdl/sdtb_pkg.sv
// Shared types, field widths and codes of the smooth division table builder.
package sdtb_pkg;

  localparam int CNT_W      = 5;   // member_count register
  localparam int KEYS_W     = 9;   // keys_per_profile register
  localparam int MEMBER_W   = 4;
  localparam int PROF_W     = 4;
  localparam int KEY_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEYS_PER_PROFILE = 1'd1;

  localparam logic [CNT_W-1:0]  MEMBER_COUNT_RST     = 5'd16;
  localparam logic [KEYS_W-1:0] KEYS_PER_PROFILE_RST = 9'd256;

  typedef struct packed {
    logic              operation;
    logic [PROF_W-1:0] profile_index;
    logic [KEY_W-1:0]  key_index;
  } req_word_t;

  typedef struct packed {
    logic [MEMBER_W-1:0] member;
    logic [STATUS_W-1:0] status;
  } rsp_word_t;

endpackage

FILE: hdl/sdtb_div.sv
// Shared restoring divider: key count by member count, one quotient bit per cycle.
module sdtb_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [sdtb_pkg::KEYS_W-1:0] dividend,
  input  logic [sdtb_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [sdtb_pkg::KEYS_W-1:0] quot,
  output logic [sdtb_pkg::CNT_W-1:0]  rem
);
  import sdtb_pkg::*;

  localparam int CW = $clog2(KEYS_W + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [CNT_W-1:0]  dsr;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quot[KEYS_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign done  = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(KEYS_W);
    end else if (busy) begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end else begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy && (cnt != '0)) begin
      // shift the next dividend bit in, subtract when it fits
      rem  <= fits ? CNT_W'(trial - {1'b0, dsr}) : trial[CNT_W-1:0];
      quot <= {quot[KEYS_W-2:0], fits};
    end
  end

endmodule

FILE: hdl/smooth_division_table_builder_unit.sv
// Top level: member table builder and reader for minimal-disruption load balancing.
//
//  channel | signals                      | word
//  --------+------------------------------+------------------------------------
//  request | req_valid, req_ready, req    | operation, profile_index, key_index
//  result  | rsp_valid, rsp_ready, rsp    | member, status
//  config  | cfg_we, cfg_index, cfg_data  | member_count, keys_per_profile
//
// A read result passes S_READ and then S_FIN, where it is loaded into the output register once
// that is free; the next request is taken after that. One word is in work at a time.
// In a build for P members and K keys, each profile makes at most P-2 pointer steps: each key
// of a lower profile costs a memory read then a write on the single table port, each key of the
// top profile a write, and each profile one pass of the 9-step shared divider.
// A refused build answers without a pass over the table. Reset is synchronous and resets control
// state, the configuration registers and rsp_valid; the table holds nothing valid until the
// first build. A stalled result waits in the output register while the next request is taken.
module smooth_division_table_builder_unit #(
  parameter int MAX_MEMBERS = 16,
  parameter int MAX_KEYS    = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  sdtb_pkg::req_word_t            req,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output sdtb_pkg::rsp_word_t            rsp,
  input  logic                           cfg_we,
  input  logic [sdtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sdtb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sdtb_pkg::*;

  localparam int PW = $clog2(MAX_MEMBERS);
  localparam int KW = $clog2(MAX_KEYS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV0 = 3'd1;
  localparam logic [2:0] S_TOP  = 3'd2;
  localparam logic [2:0] S_DIVN = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;
  localparam logic [2:0] S_READ = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    member_count;
  logic [KEYS_W-1:0]   keys_per_profile;

  logic [PW-1:0]       mem [MAX_MEMBERS][MAX_KEYS];
  logic [PW-1:0]       rdata;
  logic                mem_we, mem_re;
  logic [PW-1:0]       wr_d, rd_p;
  logic [KW-1:0]       rd_k;

  logic [PW-1:0]       prof, ptr, blk_mem;
  logic [PW-1:0]       removed, prof_dec, ptr_inc;
  logic [KW-1:0]       k;
  logic [KEYS_W-1:0]   blk_cnt, def;
  logic [KEYS_W-1:0]   q_hi, q_lo;
  logic [CNT_W-1:0]    r_hi, r_lo;
  logic [MEMBER_W-1:0] res_member;
  logic [STATUS_W-1:0] res_status;

  logic                accept, out_free, refuse, oor, last_key, is_removed, step_ptr;
  logic                div_start, div_done;
  logic [CNT_W-1:0]    div_divisor, div_rem;
  logic [KEYS_W-1:0]   div_quot;

  // Keys member m still lacks: even split over n members minus the split over n + 1.
  function automatic logic [KEYS_W-1:0] deficit(input logic [PW-1:0] m,
                                                 input logic [KEYS_W-1:0] qa,
                                                 input logic [CNT_W-1:0] ra,
                                                 input logic [KEYS_W-1:0] qb,
                                                 input logic [CNT_W-1:0] rb);
    logic [KEYS_W-1:0] d;
    d = qa - qb;
    if (int'(m) < int'(ra)) d = d + 1'b1;
    if (int'(m) < int'(rb)) d = d - 1'b1;
    return d;
  endfunction

  sdtb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (keys_per_profile),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign req_ready  = (state == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign out_free   = !rsp_valid || rsp_ready;
  assign removed    = prof + 1'b1;
  assign prof_dec   = prof - 1'b1;
  assign ptr_inc    = ptr + 1'b1;
  assign last_key   = KEYS_W'(k) == (keys_per_profile - 1'b1);
  assign is_removed = rdata == removed;
  assign step_ptr   = is_removed && (ptr < prof) && (def == '0);

  assign refuse = (member_count == '0) || (int'(member_count) > MAX_MEMBERS) ||
                  (int'(keys_per_profile) > MAX_KEYS);
  assign oor    = ({1'b0, req.profile_index} >= member_count) ||
                  (int'(req.profile_index) >= MAX_MEMBERS) ||
                  ({1'b0, req.key_index} >= keys_per_profile) ||
                  (int'(req.key_index) >= MAX_KEYS);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      member_count     <= MEMBER_COUNT_RST;
      keys_per_profile <= KEYS_PER_PROFILE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MEMBER_COUNT:     member_count     <= cfg_data[CNT_W-1:0];
        REG_KEYS_PER_PROFILE: keys_per_profile <= cfg_data[KEYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Table port control
  always_comb begin
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_d        = rdata;
    rd_p        = removed;
    rd_k        = k;
    div_start   = 1'b0;
    div_divisor = CNT_W'(prof);
    case (state)
      S_IDLE: begin
        rd_p   = PW'(req.profile_index);
        rd_k   = KW'(req.key_index);
        mem_re = accept && (req.operation == OP_READ) && !oor;
        if (accept && (req.operation == OP_BUILD) && !refuse) begin
          div_start   = 1'b1;
          div_divisor = member_count;
        end
      end
      S_TOP: begin
        mem_we    = 1'b1;
        wr_d      = blk_mem;
        div_start = last_key && (prof != '0);
      end
      S_RD: begin
        mem_re = 1'b1;
      end
      S_WR: begin
        mem_we    = !step_ptr;
        wr_d      = is_removed ? ptr : rdata;
        div_start = !step_ptr && last_key && (prof != '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[prof][k] <= wr_d;
    if (mem_re) rdata <= mem[rd_p][rd_k];
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.operation == OP_READ) begin
            state_next = oor ? S_FIN : S_READ;
          end else begin
            state_next = refuse ? S_FIN : S_DIV0;
          end
        end
      end
      S_DIV0: begin
        if (div_done) begin
          state_next = ((div_rem != '0) || (keys_per_profile == '0)) ? S_FIN : S_TOP;
        end
      end
      S_TOP: begin
        if (last_key) state_next = (prof == '0) ? S_FIN : S_DIVN;
      end
      S_DIVN: begin
        if (div_done) state_next = S_RD;
      end
      S_RD:   state_next = S_WR;
      S_WR: begin
        if (!step_ptr) begin
          if (last_key) begin
            state_next = (prof == '0) ? S_FIN : S_DIVN;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_READ: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Build datapath and result fields
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_member <= '0;
        res_status <= STAT_OK;
        if (req.operation == OP_READ) begin
          res_status <= oor ? STAT_RANGE : STAT_OK;
        end else if (refuse) begin
          res_status <= STAT_REFUSED;
        end
      end
      S_DIV0: begin
        if (div_done) begin
          if (div_rem != '0) res_status <= STAT_REFUSED;
          q_hi    <= div_quot;
          r_hi    <= div_rem;
          prof    <= PW'(member_count - 1'b1);
          k       <= '0;
          blk_cnt <= '0;
          blk_mem <= '0;
        end
      end
      S_TOP: begin
        if (blk_cnt == q_hi - 1'b1) begin
          blk_cnt <= '0;
          blk_mem <= blk_mem + 1'b1;
        end else begin
          blk_cnt <= blk_cnt + 1'b1;
        end
        k <= k + 1'b1;
        if (last_key) prof <= prof_dec;
      end
      S_DIVN: begin
        if (div_done) begin
          q_lo <= div_quot;
          r_lo <= div_rem;
          ptr  <= '0;
          def  <= deficit('0, div_quot, div_rem, q_hi, r_hi);
          k    <= '0;
        end
      end
      S_WR: begin
        if (step_ptr) begin
          // step to the next member and take its deficit
          ptr <= ptr_inc;
          def <= deficit(ptr_inc, q_lo, r_lo, q_hi, r_hi);
        end else begin
          if (is_removed && (def != '0)) def <= def - 1'b1;
          k <= k + 1'b1;
          if (last_key) begin
            prof <= prof_dec;
            q_hi <= q_lo;
            r_hi <= r_lo;
          end
        end
      end
      S_READ: begin
        res_member <= MEMBER_W'(rdata);
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      rsp.member <= res_member;
      rsp.status <= res_status;
    end
  end

endmodule

FILE: hdl/sdtb_checker.sv
// Port-level checks on the table builder, attached to the top level by bind.
module sdtb_checker (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input sdtb_pkg::req_word_t req,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input sdtb_pkg::rsp_word_t rsp
);
  import sdtb_pkg::*;

  // one word in work at a time: busy right after taking one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while a word is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == STAT_OK || rsp.status == STAT_REFUSED ||
                   rsp.status == STAT_RANGE))
    else $error("result carries an unknown status");

  a_member_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status != STAT_OK) |-> (rsp.member == '0))
    else $error("error result with a nonzero member");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result dropped or changed");

endmodule

bind smooth_division_table_builder_unit sdtb_checker u_checker (.*);
